### rtl/core/dtsp_pkg.sv
// ============================================================================
// dtsp_pkg
// Shared types, codes and helpers of the decimal token string parser.
// ============================================================================
package dtsp_pkg;

    // Register index of the configuration port
    localparam logic REG_TOKEN_MODE = 1'b0;

    // Token modes
    localparam logic MODE_SIGNED64   = 1'b0;
    localparam logic MODE_UNSIGNED128 = 1'b1;

    // Character codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Bias added to the signed value in 64-bit mode
    localparam logic [63:0] OFFSET64 = 64'h7FFF_FFFF_FFFF_FFFF;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PHASE_SKIP   = 3'b001,
        PHASE_DIGITS = 3'b010,
        PHASE_STOP   = 3'b100
    } phase_t;

    // One input item as held in the input register
    typedef struct packed {
        logic [7:0] ch;
        logic       ch_valid;
        logic       last;
    } item_t;

    // Finished raw token handed to the formatter
    typedef struct packed {
        logic [63:0] accum_hi;
        logic [63:0] accum_lo;
        logic        negative;
        logic        mode;
    } token_raw_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

### rtl/core/dtsp_parse.sv
// ============================================================================
// dtsp_parse
// Character parser: skips white space, takes an optional minus, and
// accumulates decimal digits with a 128-bit shift-add multiply by ten.
// ============================================================================
module dtsp_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_v,
    input  dtsp_pkg::item_t      item,
    input  logic                 token_mode,
    input  logic                 fmt_ready,
    output logic                 item_take,
    output logic                 raw_v,
    output dtsp_pkg::token_raw_t raw,
    output logic                 state_clear
);

    dtsp_pkg::phase_t     phase_reg, phase_next;
    logic                 negative_reg, negative_next;
    logic [127:0]         accum_reg, accum_next;
    logic                 raw_v_reg, raw_v_next;
    dtsp_pkg::token_raw_t raw_reg;

    logic                 raw_free;
    logic [127:0]         accum_mac;
    logic [3:0]           digit;
    dtsp_pkg::phase_t     phase_upd;
    logic                 negative_upd;
    logic [127:0]         accum_upd;

    // Take an item unless it ends a token and the raw slot is still full
    assign raw_free  = !raw_v_reg || fmt_ready;
    assign item_take = item_v && (!item.last || raw_free);

    // Multiply by ten and add the digit
    assign digit     = 4'(item.ch - dtsp_pkg::CHAR_ZERO);
    assign accum_mac = (accum_reg << 3) + (accum_reg << 1) + {124'd0, digit};

    // Per-character phase update
    always_comb
    begin
        phase_upd    = phase_reg;
        negative_upd = negative_reg;
        accum_upd    = accum_reg;
        if (item.ch_valid)
        begin
            case (phase_reg)
                dtsp_pkg::PHASE_SKIP:
                begin
                    if (!dtsp_pkg::is_blank(item.ch))
                    begin
                        if (token_mode == dtsp_pkg::MODE_SIGNED64 &&
                            item.ch == dtsp_pkg::CHAR_MINUS)
                        begin
                            phase_upd    = dtsp_pkg::PHASE_DIGITS;
                            negative_upd = 1'b1;
                        end
                        else if (dtsp_pkg::is_digit(item.ch))
                        begin
                            phase_upd = dtsp_pkg::PHASE_DIGITS;
                            accum_upd = accum_mac;
                        end
                        else
                        begin
                            phase_upd = dtsp_pkg::PHASE_STOP;
                        end
                    end
                end
                dtsp_pkg::PHASE_DIGITS:
                begin
                    if (dtsp_pkg::is_digit(item.ch))
                        accum_upd = accum_mac;
                    else
                        phase_upd = dtsp_pkg::PHASE_STOP;
                end
                default:
                begin
                    phase_upd = phase_reg;
                end
            endcase
        end
    end

    // Clear the state after the last item, otherwise advance it
    always_comb
    begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        accum_next    = accum_reg;
        raw_v_next    = raw_v_reg && !fmt_ready;
        if (item_take)
        begin
            if (item.last)
            begin
                phase_next    = dtsp_pkg::PHASE_SKIP;
                negative_next = 1'b0;
                accum_next    = '0;
                raw_v_next    = 1'b1;
            end
            else
            begin
                phase_next    = phase_upd;
                negative_next = negative_upd;
                accum_next    = accum_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= dtsp_pkg::PHASE_SKIP;
            negative_reg <= 1'b0;
            accum_reg    <= '0;
            raw_v_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            accum_reg    <= accum_next;
            raw_v_reg    <= raw_v_next;
        end
    end

    // Hold the finished token for the formatter
    always_ff @(posedge clk)
    begin
        if (item_take && item.last)
        begin
            raw_reg.accum_hi <= accum_upd[127:64];
            raw_reg.accum_lo <= accum_upd[63:0];
            raw_reg.negative <= negative_upd;
            raw_reg.mode     <= token_mode;
        end
    end

    assign raw_v       = raw_v_reg;
    assign raw         = raw_reg;
    assign state_clear = (phase_reg == dtsp_pkg::PHASE_SKIP) && !negative_reg &&
                         (accum_reg == '0);

endmodule

### rtl/core/dtsp_format.sv
// ============================================================================
// dtsp_format
// Token formatter: applies sign and offset in 64-bit mode and holds the
// result item in the output register.
// ============================================================================
module dtsp_format (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 raw_v,
    input  dtsp_pkg::token_raw_t raw,
    output logic                 raw_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          token_hi,
    output logic [63:0]          token_lo
);

    logic        out_v_reg, out_v_next;
    logic [63:0] hi_reg, lo_reg;
    logic [63:0] hi_fmt, lo_fmt;
    logic        load;

    // Take a new token when the output register is empty or draining
    assign raw_ready = !out_v_reg || out_ready;
    assign load      = raw_v && raw_ready;

    // Negate and bias in 64-bit mode, pass through in 128-bit mode
    always_comb
    begin
        if (raw.mode == dtsp_pkg::MODE_UNSIGNED128)
        begin
            hi_fmt = raw.accum_hi;
            lo_fmt = raw.accum_lo;
        end
        else
        begin
            hi_fmt = '0;
            if (raw.negative)
                lo_fmt = dtsp_pkg::OFFSET64 - raw.accum_lo;
            else
                lo_fmt = raw.accum_lo + dtsp_pkg::OFFSET64;
        end
    end

    assign out_v_next = load || (out_v_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= out_v_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hi_reg <= hi_fmt;
            lo_reg <= lo_fmt;
        end
    end

    assign out_valid = out_v_reg;
    assign token_hi  = hi_reg;
    assign token_lo  = lo_reg;

endmodule

### rtl/core/decimal_token_string_parser_top.sv
// ============================================================================
// decimal_token_string_parser_top
// Parses a decimal token string, one character per item, into a 128-bit or
// offset 64-bit token.
// ============================================================================
// Usage:
//   Input stream s_*: s_tdata is one character byte, s_tuser flags that the
//   byte is a real character (low means end marker only), s_tlast ends the
//   string. Output stream m_*: one item per string, token_hi in
//   m_tdata[63:0] and token_lo in m_tdata[127:64].
//   The APB port holds token_mode at address 0 (0 = signed 64-bit with
//   offset, 1 = unsigned 128-bit); write it only while no string is open.
//   Throughput is one item per cycle unless an s_tlast item waits for the raw
//   slot. A token reaches m_tvalid via these registers in order: the item
//   with s_tlast sits in the input register, the parse stage with the 128-bit
//   multiply-by-ten accumulator loads the raw token slot, and the format
//   stage with the 64-bit sign and offset add loads the output register.
//   When the receiver stalls, the output register and the raw token slot
//   fill; characters that do not end a string still flow into the
//   accumulator, and s_tready drops only when an item with s_tlast waits
//   for the raw slot.
//   Reset clears every valid flag, the accumulator, the phase and
//   token_mode.
// ============================================================================
module decimal_token_string_parser_top (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] ch
    input  logic         s_tuser,   // [0] ch_valid
    input  logic         s_tlast,
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] token_hi, [127:64] token_lo
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic                 token_mode_reg, token_mode_next;
    logic                 cfg_write;
    logic                 in_v_reg, in_v_next;
    dtsp_pkg::item_t      in_reg;
    logic                 item_take;
    logic                 raw_v;
    dtsp_pkg::token_raw_t raw;
    logic                 raw_ready;
    logic                 state_clear;
    logic [63:0]          token_hi, token_lo;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == dtsp_pkg::REG_TOKEN_MODE);
    assign token_mode_next = cfg_write ? pwdata[0] : token_mode_reg;
    assign prdata = (paddr[2] == dtsp_pkg::REG_TOKEN_MODE) ?
                    {31'd0, token_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            token_mode_reg <= dtsp_pkg::MODE_SIGNED64;
        else
            token_mode_reg <= token_mode_next;
    end

    // Input register
    assign s_tready  = !in_v_reg || item_take;
    assign in_v_next = (s_tvalid && s_tready) || (in_v_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else
            in_v_reg <= in_v_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.ch       <= s_tdata;
            in_reg.ch_valid <= s_tuser;
            in_reg.last     <= s_tlast;
        end
    end

    // Parse stage
    dtsp_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_v      (in_v_reg),
        .item        (in_reg),
        .token_mode  (token_mode_reg),
        .fmt_ready   (raw_ready),
        .item_take   (item_take),
        .raw_v       (raw_v),
        .raw         (raw),
        .state_clear (state_clear)
    );

    // Format stage and output register
    dtsp_format u_format (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_v     (raw_v),
        .raw       (raw),
        .raw_ready (raw_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .token_hi  (token_hi),
        .token_lo  (token_lo)
    );

    assign m_tdata = {token_lo, token_hi};

    // State returns to reset after an item that ends a string
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && in_reg.last |=> state_clear)
        else $error("parser state not cleared after last item");

    // Input stalls only behind a waiting last item and a full raw slot
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_v_reg && in_reg.last && raw_v && !raw_ready)
        else $error("input stalled without cause");

    // A 64-bit mode token carries a zero upper word
    a_hi_zero_mode0: assert property (@(posedge clk) disable iff (!rst_n)
        raw_v && raw_ready && (raw.mode == dtsp_pkg::MODE_SIGNED64)
        |=> m_tvalid && (m_tdata[63:0] == 64'd0))
        else $error("upper word not zero in 64-bit mode");

endmodule
